// ===== rtl/core/lock_actuator_retry_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LOCK_ACTUATOR_RETRY_CONTROLLER_TOP_MACROS_SVH
`define LOCK_ACTUATOR_RETRY_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lar_pkg.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - package
// Operation and status codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package lar_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_OPER  = 2'd1;
    localparam logic [1:0] ST_LFAIL = 2'd2;
    localparam logic [1:0] ST_UFAIL = 2'd3;

    localparam logic [2:0] CFG_OPERATING_TIME = 3'd0;
    localparam logic [2:0] CFG_BREAK_TIME     = 3'd1;
    localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_SENSE_POLARITY = 3'd3;
    localparam logic [2:0] CFG_SENSE_SETTLE   = 3'd4;

    localparam logic [9:0]  RST_OPERATING_TIME = 10'd300;
    localparam logic [15:0] RST_BREAK_TIME     = 16'd1000;
    localparam logic [7:0]  RST_RETRY_LIMIT    = 8'd5;
    localparam logic        RST_SENSE_POLARITY = 1'b0;
    localparam logic [15:0] RST_SENSE_SETTLE   = 16'd0;

    localparam logic [15:0] PRE_LOCK_DELAY_MS  = 16'd500;

    typedef struct packed {
        logic [9:0]  operating_time_ms;
        logic [15:0] break_time_ms;
        logic [7:0]  retry_limit;
        logic        sense_active_high;
        logic [15:0] sense_settle_ms;
    } lar_cfg_t;

    typedef struct packed {
        logic       busy_res;
        logic [1:0] lock_status;
        logic       drive_b;
        logic       drive_a;
    } lar_res_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ===== rtl/core/lar_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - configuration registers
// Holds the five timing and polarity registers written over the config channel.
// ----------------------------------------------------------------------------
module lar_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [15:0]       wr_data,
    output lar_pkg::lar_cfg_t cfg
);
    import lar_pkg::*;

    lar_cfg_t cfg_reg;
    lar_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_OPERATING_TIME: cfg_next.operating_time_ms = wr_data[9:0];
                CFG_BREAK_TIME:     cfg_next.break_time_ms     = wr_data;
                CFG_RETRY_LIMIT:    cfg_next.retry_limit       = wr_data[7:0];
                CFG_SENSE_POLARITY: cfg_next.sense_active_high = wr_data[0];
                CFG_SENSE_SETTLE:   cfg_next.sense_settle_ms   = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operating_time_ms <= RST_OPERATING_TIME;
            cfg_reg.break_time_ms     <= RST_BREAK_TIME;
            cfg_reg.retry_limit       <= RST_RETRY_LIMIT;
            cfg_reg.sense_active_high <= RST_SENSE_POLARITY;
            cfg_reg.sense_settle_ms   <= RST_SENSE_SETTLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lar_core.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - sequencing core
// Phase machine, timers, request latches and attempt budget; one item a step.
// ----------------------------------------------------------------------------
module lar_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [1:0]        operation,
    input  logic              sense_level,
    input  lar_pkg::lar_cfg_t cfg,
    output lar_pkg::lar_res_t res_next
);
    import lar_pkg::*;

    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_PRE    = 3'd1;
    localparam logic [2:0] PH_DRIVE  = 3'd2;
    localparam logic [2:0] PH_SETTLE = 3'd3;
    localparam logic [2:0] PH_BREAK  = 3'd4;

    logic [2:0]  phase_reg,          phase_next;
    logic [15:0] timer_reg,          timer_next;
    logic [7:0]  attempts_reg,       attempts_next;
    logic        pend_lock_reg,      pend_lock_next;
    logic        pend_unlock_reg,    pend_unlock_next;
    logic        dir_lock_reg,       dir_lock_next;
    logic        retry_reg,          retry_next;
    logic [15:0] since_reg,          since_next;
    logic [1:0]  status_reg,         status_next;

    logic locked;
    logic attempt_ok;

    always_comb
    begin
        phase_next       = phase_reg;
        timer_next       = timer_reg;
        attempts_next    = attempts_reg;
        pend_lock_next   = pend_lock_reg;
        pend_unlock_next = pend_unlock_reg;
        dir_lock_next    = dir_lock_reg;
        retry_next       = retry_reg;
        since_next       = since_reg;
        status_next      = status_reg;
        locked           = (sense_level == cfg.sense_active_high);
        attempt_ok       = 1'b0;

        unique case (operation)
            OP_LOCK:
            begin
                pend_lock_next = 1'b1;
                status_next    = ST_OPER;
                attempts_next  = cfg.retry_limit;
            end
            OP_UNLOCK:
            begin
                pend_unlock_next = 1'b1;
                status_next      = ST_OPER;
                attempts_next    = cfg.retry_limit;
            end
            OP_TICK:
            begin
                since_next = sat_inc16(since_reg);
                if (phase_reg == PH_WAIT)
                begin
                    if (pend_lock_reg || pend_unlock_reg || retry_reg)
                    begin
                        // unlock (fresh or retried) wins; only a fresh lock waits first
                        if (pend_unlock_reg || (retry_reg && !dir_lock_reg))
                        begin
                            dir_lock_next = 1'b0;
                            phase_next    = PH_DRIVE;
                        end
                        else if (pend_lock_reg)
                        begin
                            dir_lock_next = 1'b1;
                            phase_next    = PH_PRE;
                        end
                        else
                        begin
                            dir_lock_next = 1'b1;
                            phase_next    = PH_DRIVE;
                        end
                        pend_lock_next   = 1'b0;
                        pend_unlock_next = 1'b0;
                        retry_next       = 1'b0;
                        timer_next       = '0;
                    end
                end
                else
                begin
                    timer_next = sat_inc16(timer_reg);
                end

                // phases only move forward, so one pass of the cascade resolves
                // every zero-length phase in the same tick
                if (phase_next == PH_PRE && timer_next >= PRE_LOCK_DELAY_MS)
                begin
                    phase_next = PH_DRIVE;
                    timer_next = '0;
                end
                if (phase_next == PH_DRIVE &&
                    timer_next >= {6'd0, cfg.operating_time_ms})
                begin
                    phase_next = PH_SETTLE;
                    timer_next = '0;
                end
                if (phase_next == PH_SETTLE && timer_next >= cfg.sense_settle_ms)
                begin
                    attempt_ok = dir_lock_next ? locked : !locked;
                    if (attempt_ok)
                    begin
                        status_next = ST_IDLE;
                    end
                    else if (attempts_next > 8'd1)
                    begin
                        attempts_next = attempts_next - 8'd1;
                        retry_next    = 1'b1;
                    end
                    else
                    begin
                        status_next = dir_lock_next ? ST_LFAIL : ST_UFAIL;
                    end
                    phase_next = PH_BREAK;
                    timer_next = '0;
                end
                if (phase_next == PH_BREAK && since_next >= cfg.break_time_ms)
                begin
                    since_next = '0;
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
            end
            default:
            begin
                // code three: no change
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        res_next.drive_a     = 1'b0;
        res_next.drive_b     = 1'b0;
        res_next.lock_status = status_next;
        res_next.busy_res    = (phase_next != PH_WAIT);
        if (phase_next == PH_DRIVE)
        begin
            res_next.drive_a = dir_lock_next;
            res_next.drive_b = !dir_lock_next;
        end
        else if (phase_next == PH_SETTLE)
        begin
            res_next.drive_a = 1'b1;
            res_next.drive_b = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            timer_reg       <= '0;
            attempts_reg    <= '0;
            pend_lock_reg   <= 1'b0;
            pend_unlock_reg <= 1'b0;
            dir_lock_reg    <= 1'b0;
            retry_reg       <= 1'b0;
            since_reg       <= '0;
            status_reg      <= ST_IDLE;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            timer_reg       <= timer_next;
            attempts_reg    <= attempts_next;
            pend_lock_reg   <= pend_lock_next;
            pend_unlock_reg <= pend_unlock_next;
            dir_lock_reg    <= dir_lock_next;
            retry_reg       <= retry_next;
            since_reg       <= since_next;
            status_reg      <= status_next;
        end
    end

endmodule

// ===== rtl/core/lock_actuator_retry_controller_top.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - top level
// Socket lock motor driver with retries, break wait and sensor check.
//
//   channel  dir  payload                                  handshake
//   s_*      in   tuser: operation; tdata: sense_level     s_tvalid/s_tready
//   m_*      out  tdata: drive_a, drive_b, status, busy    m_tvalid/m_tready
//   cfg_*    in   cfg_index, cfg_data                      cfg_valid/cfg_ready
//
// One item per cycle sustained while no result stalls; each input beat passes
// the input register, then the phase/timer update into the result register.
// rst_n clears all control state and loads register defaults; no clear pass.
// A stalled result holds in the output register; the input register keeps
// taking beats until both stages are full, and a released stall resumes at
// one beat per cycle with no bubble. cfg_ready is always high.
// ----------------------------------------------------------------------------
module lock_actuator_retry_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] sense_level, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] drive_a, [1] drive_b, [3:2] lock_status,
                                   // [4] busy_res, [7:5] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lar_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_op_reg;
    logic       in_sense_reg;
    logic       out_valid_reg, out_valid_next;
    lar_res_t   out_res_reg;
    lar_res_t   res_next;
    lar_cfg_t   cfg;
    logic       step_en;
    logic       in_take;

    assign cfg_ready = 1'b1;
    assign step_en   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_en;
    assign in_take   = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    lar_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lar_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .operation   (in_op_reg),
        .sense_level (in_sense_reg),
        .cfg         (cfg),
        .res_next    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_en)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= s_tuser;
            in_sense_reg <= s_tdata[0];
        end
        if (step_en)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.busy_res, out_res_reg.lock_status,
                       out_res_reg.drive_b, out_res_reg.drive_a};

endmodule

// ===== rtl/core/lar_checker.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - port checker
// Watches the top-level ports for stall, flow and drive consistency slips.
// ----------------------------------------------------------------------------
`include "lock_actuator_retry_controller_top_macros.svh"

module lar_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    logic out_stall;
    logic wire_on;

    assign out_stall = m_tvalid && !m_tready;
    assign wire_on   = m_tvalid && (m_tdata[0] || m_tdata[1]);

    // a stalled result beat holds
    `LAR_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // input backpressure only comes from a stalled output
    `LAR_ASSERT_NOW(a_in_stall, !s_tready, out_stall, "input stalled without output stall")

    // the motor is only driven while busy
    `LAR_ASSERT_NOW(a_drive_busy, wire_on, m_tdata[4], "wires driven while not busy")

    // padding above the result fields stays zero
    `LAR_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[7:5] == 3'd0, "result padding not zero")

endmodule

bind lock_actuator_retry_controller_top lar_checker u_lar_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Lock actuator retry controller - testbench
// Streams 1 ms ticks, lock and unlock requests and no-op items into the block
// with random gaps and output stalls. A cycle-free model of the actuator
// sequencer predicts the wire levels, status and busy flag for every input
// beat, and each result beat is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lar_pkg::*;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam int         SENSE_ANY   = 2;
    localparam int         STALL_LIMIT = 2000;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_PRELOCK,
        STEP_DRIVE,
        STEP_SETTLE,
        STEP_BREAK
    } motor_step_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [0] sense_level, [7:1] zero
    logic [1:0]  s_tuser   = 2'd0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;            // [0] drive_a, [1] drive_b, [3:2] lock_status,
                                     // [4] busy_res, [7:5] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data  = 16'd0;

    // actuator model state
    lar_cfg_t    regs_model;
    motor_step_t step;
    logic [15:0] step_ticks;
    logic [15:0] ticks_since_end;
    logic [7:0]  tries_left;
    logic        want_lock;
    logic        want_unlock;
    logic        retry_due;
    logic        heading_lock;
    logic [1:0]  status_now;

    lar_res_t    wire_status_q[$];

    int tx_gap_max    = 18;
    int rx_stall_max  = 18;
    int items_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    always #10 clk = ~clk;

    lock_actuator_retry_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int draw_wait(input int max_wait);
        return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic reset_model();
        regs_model.operating_time_ms = RST_OPERATING_TIME;
        regs_model.break_time_ms     = RST_BREAK_TIME;
        regs_model.retry_limit       = RST_RETRY_LIMIT;
        regs_model.sense_active_high = RST_SENSE_POLARITY;
        regs_model.sense_settle_ms   = RST_SENSE_SETTLE;
        step            = STEP_IDLE;
        step_ticks      = 16'd0;
        ticks_since_end = 16'd0;
        tries_left      = 8'd0;
        want_lock       = 1'b0;
        want_unlock     = 1'b0;
        retry_due       = 1'b0;
        heading_lock    = 1'b0;
        status_now      = ST_IDLE;
    endtask

    // Advance the actuator model by one input item and return its result.
    function automatic lar_res_t advance_lock_fsm(input logic [1:0] op, input logic sense);
        lar_res_t res;
        logic     fresh;
        logic     moved;
        logic     correct;
        fresh = 1'b0;
        if (op == OP_LOCK || op == OP_UNLOCK) begin
            if (op == OP_LOCK)
                want_lock = 1'b1;
            else
                want_unlock = 1'b1;
            status_now = ST_OPER;
            tries_left = regs_model.retry_limit;
        end else if (op == OP_TICK) begin
            ticks_since_end = bump16(ticks_since_end);
            if (step == STEP_IDLE) begin
                if (want_lock || want_unlock || retry_due) begin
                    // pending unlock beats lock; only a fresh lock waits first
                    if (want_unlock || (retry_due && !heading_lock)) begin
                        heading_lock = 1'b0;
                    end else if (want_lock) begin
                        heading_lock = 1'b1;
                        fresh = 1'b1;
                    end else begin
                        heading_lock = 1'b1;
                    end
                    want_lock   = 1'b0;
                    want_unlock = 1'b0;
                    retry_due   = 1'b0;
                    step        = fresh ? STEP_PRELOCK : STEP_DRIVE;
                    step_ticks  = 16'd0;
                end
            end else begin
                step_ticks = bump16(step_ticks);
            end
            // zero-length phases fall through within the same tick
            moved = 1'b1;
            while (moved) begin
                moved = 1'b0;
                if (step == STEP_PRELOCK && step_ticks >= PRE_LOCK_DELAY_MS) begin
                    step = STEP_DRIVE;
                    step_ticks = 16'd0;
                    moved = 1'b1;
                end else if (step == STEP_DRIVE &&
                             step_ticks >= {6'd0, regs_model.operating_time_ms}) begin
                    step = STEP_SETTLE;
                    step_ticks = 16'd0;
                    moved = 1'b1;
                end else if (step == STEP_SETTLE &&
                             step_ticks >= regs_model.sense_settle_ms) begin
                    correct = (sense == regs_model.sense_active_high) ~^ heading_lock;
                    if (correct) begin
                        status_now = ST_IDLE;
                    end else if (tries_left > 8'd1) begin
                        tries_left = tries_left - 8'd1;
                        retry_due = 1'b1;
                    end else begin
                        status_now = heading_lock ? ST_LFAIL : ST_UFAIL;
                    end
                    step = STEP_BREAK;
                    step_ticks = 16'd0;
                    moved = 1'b1;
                end else if (step == STEP_BREAK &&
                             ticks_since_end >= regs_model.break_time_ms) begin
                    ticks_since_end = 16'd0;
                    step = STEP_IDLE;
                    step_ticks = 16'd0;
                    moved = 1'b1;
                end
            end
        end
        res.drive_a     = (step == STEP_SETTLE) || (step == STEP_DRIVE && heading_lock);
        res.drive_b     = (step == STEP_SETTLE) || (step == STEP_DRIVE && !heading_lock);
        res.lock_status = status_now;
        res.busy_res    = (step != STEP_IDLE);
        return res;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic sense);
        int gap;
        gap = draw_wait(tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, sense};
        do @(posedge clk); while (!s_tready);
        wire_status_q.push_back(advance_lock_fsm(op, sense));
        items_sent++;
    endtask

    task automatic run_ticks(input int count, input int sense_sel);
        repeat (count)
            send_item(OP_TICK,
                      (sense_sel == SENSE_ANY) ? 1'($urandom_range(0, 1)) : sense_sel[0]);
    endtask

    // Drop valid, then wait for every result and let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (wire_status_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_OPERATING_TIME: regs_model.operating_time_ms = value[9:0];
            CFG_BREAK_TIME:     regs_model.break_time_ms     = value;
            CFG_RETRY_LIMIT:    regs_model.retry_limit       = value[7:0];
            CFG_SENSE_POLARITY: regs_model.sense_active_high = value[0];
            CFG_SENSE_SETTLE:   regs_model.sense_settle_ms   = value;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [9:0] op_ms, input logic [15:0] brk_ms,
                            input logic [7:0] tries, input logic pol,
                            input logic [15:0] settle_ms);
        write_reg(CFG_OPERATING_TIME, {6'd0, op_ms});
        write_reg(CFG_BREAK_TIME, brk_ms);
        write_reg(CFG_RETRY_LIMIT, {8'd0, tries});
        write_reg(CFG_SENSE_POLARITY, {15'd0, pol});
        write_reg(CFG_SENSE_SETTLE, settle_ms);
    endtask

    // Default registers: no-ops, both requests latched, unlock taking priority.
    task automatic test_reset_defaults();
        tx_gap_max   = 18;
        rx_stall_max = 18;
        send_item(OP_TICK, 1'b0);
        send_item(OP_NOP, 1'b1);
        send_item(OP_NOP, 1'b0);
        send_item(OP_UNLOCK, 1'b1);
        send_item(OP_LOCK, 1'b0);
        send_item(OP_TICK, 1'b0);
        run_ticks(3, SENSE_ANY);
    endtask

    // Zero-length phases, budgets of zero and one, retries, mid-run requests.
    task automatic test_corner_cases();
        drain_results();
        set_regs(10'd0, 16'd0, 8'd1, 1'b1, 16'd0);
        send_item(OP_UNLOCK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_item(OP_UNLOCK, 1'b0);
        send_item(OP_TICK, 1'b0);
        send_item(OP_LOCK, 1'b1);
        send_item(OP_UNLOCK, 1'b1);
        send_item(OP_TICK, 1'b0);
        drain_results();
        write_reg(CFG_RETRY_LIMIT, 16'd0);
        send_item(OP_UNLOCK, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        drain_results();
        set_regs(10'd2, 16'd3, 8'd3, 1'b0, 16'd1);
        send_item(OP_UNLOCK, 1'b0);
        run_ticks(8, 0);
        send_item(OP_LOCK, 1'b1);
        run_ticks(4, 1);
    endtask

    // One lock run through the pre-lock wait: two wrong readings, then a
    // last attempt on a random sensor level.
    task automatic test_lock_retries();
        drain_results();
        set_regs(10'd3, 16'd4, 8'd3, 1'b0, 16'd2);
        tx_gap_max   = 0;
        rx_stall_max = 18;
        send_item(OP_LOCK, 1'b1);
        run_ticks(512, 1);
        tx_gap_max   = 18;
        rx_stall_max = 0;
        run_ticks(12, SENSE_ANY);
    endtask

    // Stretches of random traffic, each with its own small register set.
    task automatic test_random_traffic();
        int pick;
        for (int stretch = 0; stretch < 2; stretch++) begin
            drain_results();
            set_regs(10'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                     8'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 4)));
            tx_gap_max   = $urandom_range(0, 1) ? 18 : 0;
            rx_stall_max = $urandom_range(0, 1) ? 18 : 0;
            repeat (15) begin
                pick = $urandom_range(0, 99);
                if (pick < 74)
                    send_item(OP_TICK, 1'($urandom_range(0, 1)));
                else if (pick < 77)
                    send_item(OP_LOCK, 1'($urandom_range(0, 1)));
                else if (pick < 95)
                    send_item(OP_UNLOCK, 1'($urandom_range(0, 1)));
                else
                    send_item(OP_NOP, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Largest register values, then a zero operating time mid-operation.
    task automatic test_register_extremes();
        drain_results();
        tx_gap_max   = 18;
        rx_stall_max = 18;
        set_regs(10'h3FF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF);
        send_item(OP_UNLOCK, 1'b0);
        run_ticks(12, SENSE_ANY);
        send_item(OP_LOCK, 1'b1);
        run_ticks(4, SENSE_ANY);
        drain_results();
        write_reg(CFG_OPERATING_TIME, 16'd0);
        run_ticks(6, SENSE_ANY);
    endtask

    // Result side: stall at random, then compare each beat with the oldest prediction.
    initial begin
        lar_res_t got;
        lar_res_t want;
        int       stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_wait(rx_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = lar_res_t'(m_tdata[4:0]);
            results_seen++;
            if (wire_status_q.size() == 0) begin
                $error("result beat 0x%02h arrived with nothing expected", m_tdata);
                fail_count++;
            end else begin
                want = wire_status_q.pop_front();
                if (got.drive_a !== want.drive_a) begin
                    $error("drive_a: expected %0d, got %0d", want.drive_a, got.drive_a);
                    fail_count++;
                end
                if (got.drive_b !== want.drive_b) begin
                    $error("drive_b: expected %0d, got %0d", want.drive_b, got.drive_b);
                    fail_count++;
                end
                if (got.lock_status !== want.lock_status) begin
                    $error("lock_status: expected %0d, got %0d",
                           want.lock_status, got.lock_status);
                    fail_count++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, wire_status_q.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    initial begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_corner_cases();
        test_lock_retries();
        test_random_traffic();
        test_register_extremes();
        drain_results();
        if (wire_status_q.size() != 0) begin
            $error("%0d expected results never arrived", wire_status_q.size());
            fail_count++;
        end
        $display("run covered %0d input beats, %0d result beats, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("lock retries, unlock priority, zero-length phases, register extremes");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
